>>> design/bda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg: shared constants and types of the binary to decimal ASCII block
// Widths, character codes, register indexes and the digit row geometry.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int MAX_DIGITS     = 10;

  // double dabble bits taken per cycle by every digit cell
  localparam int BITS_PER_STEP  = 3;
  localparam int STEPS          = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_BITS       = STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_BITS  = $clog2(STEPS);

  localparam int COUNT_BITS     = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_IDX_BITS = $clog2(MAX_DIGITS);

  localparam int CFG_BITS       = 4;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAC_DIGITS = 2'd1;

  localparam logic [CFG_BITS-1:0] DIGIT_COUNT_RESET = 4'd10;
  localparam logic [CFG_BITS-1:0] FRAC_DIGITS_RESET = 4'd0;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_POINT = 7'd46;

  typedef logic [3:0] digit_t;

  // effective string format handed to the serializer
  typedef struct packed {
    logic [COUNT_BITS-1:0] nd;
    logic [COUNT_BITS-1:0] nf;
  } fmt_t;

endpackage
`default_nettype wire

>>> design/bda_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_cell: one BCD digit of the double dabble row
// Holds one decimal digit and runs BITS_PER_STEP add-3 / shift steps per
// enabled cycle, taking bits from its lower neighbor and passing carries up.
// ----------------------------------------------------------------------------
module bda_cell (
  input  wire                               clk,
  input  wire                               clear,
  input  wire                               en,
  input  wire  [bda_pkg::BITS_PER_STEP-1:0] carry_in,
  output logic [bda_pkg::BITS_PER_STEP-1:0] carry_out,
  output bda_pkg::digit_t                   digit
);

  bda_pkg::digit_t digit_next;

  always_comb begin
    bda_pkg::digit_t q;
    bda_pkg::digit_t adj;
    q   = digit;
    adj = digit;
    for (int k = 0; k < bda_pkg::BITS_PER_STEP; k++) begin
      adj          = (q >= 4'd5) ? q + 4'd3 : q;
      carry_out[k] = adj[3];
      q            = {adj[2:0], carry_in[k]};
    end
    digit_next = q;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (en) begin
      digit <= digit_next;
    end
  end

endmodule
`default_nettype wire

>>> design/bda_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_conv: binary to BCD converter built from a row of digit cells
// Shifts the value into the cell row BITS_PER_STEP bits per cycle, holds the
// finished digits until the serializer takes them.
// ----------------------------------------------------------------------------
module bda_conv (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire  [bda_pkg::VALUE_BITS-1:0] value,
  input  wire                            take,
  output logic                           busy,
  output logic                           full,
  output bda_pkg::digit_t                digits [bda_pkg::MAX_DIGITS]
);

  localparam int S = bda_pkg::BITS_PER_STEP;

  logic                               running;
  logic [bda_pkg::STEP_CNT_BITS-1:0]  cnt;
  logic [bda_pkg::PAD_BITS-1:0]       bin;
  logic                               accept;
  logic [S-1:0]                       chain [bda_pkg::MAX_DIGITS];

  assign busy   = running || (full && !take);
  assign accept = start && !busy;

  // step k feeds the next most significant bit of the value
  always_comb begin
    for (int k = 0; k < S; k++) begin
      chain[0][k] = bin[bda_pkg::PAD_BITS-1-k];
    end
  end

  for (genvar j = 0; j < bda_pkg::MAX_DIGITS; j++) begin : g_cell
    if (j < bda_pkg::MAX_DIGITS - 1) begin : g_mid
      bda_cell u_cell (
        .clk       (clk),
        .clear     (accept),
        .en        (running),
        .carry_in  (chain[j]),
        .carry_out (chain[j+1]),
        .digit     (digits[j])
      );
    end else begin : g_top
      // carries out of the top digit are weight beyond the digit row: dropped
      bda_cell u_cell (
        .clk       (clk),
        .clear     (accept),
        .en        (running),
        .carry_in  (chain[j]),
        .carry_out (),
        .digit     (digits[j])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      full    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (take) begin
        full <= 1'b0;
      end
      if (accept) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == bda_pkg::STEP_CNT_BITS'(bda_pkg::STEPS - 1)) begin
          running <= 1'b0;
          full    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= bda_pkg::PAD_BITS'(value);
    end else if (running) begin
      bin <= bin << S;
    end
  end

  a_done_fills : assert property (@(posedge clk) disable iff (rst)
    running && cnt == bda_pkg::STEP_CNT_BITS'(bda_pkg::STEPS - 1) |=> full)
    else $error("conversion finished without holding its digits");

  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    !(running && full))
    else $error("converter running over unclaimed digits");

endmodule
`default_nettype wire

>>> design/bda_ser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_ser: character serializer
// Emits the held digits most significant first, one character a cycle,
// inserting the decimal point before the fraction digits.
// ----------------------------------------------------------------------------
module bda_ser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load,
  input  wire bda_pkg::fmt_t   fmt,
  input  wire bda_pkg::digit_t digits [bda_pkg::MAX_DIGITS],
  output logic                 free,
  output logic                 strobe,
  output logic [6:0]           ascii_char,
  output logic                 last_char
);

  logic                               active;
  logic                               pt_done;
  logic [bda_pkg::COUNT_BITS-1:0]     pos;
  bda_pkg::fmt_t                      cur;
  bda_pkg::digit_t                    dig [bda_pkg::MAX_DIGITS];

  logic                               point_due;
  logic                               last_digit;
  logic [bda_pkg::COUNT_BITS-1:0]     idx_full;
  logic [bda_pkg::DIGIT_IDX_BITS-1:0] idx;

  assign point_due  = (cur.nf != '0) && !pt_done && (pos == cur.nd - cur.nf);
  assign last_digit = (pos == cur.nd - 1'b1);
  // cell 0 holds the least significant digit
  assign idx_full   = cur.nd - 1'b1 - pos;
  assign idx        = bda_pkg::DIGIT_IDX_BITS'(idx_full);
  assign free       = !active || (!point_due && last_digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      strobe    <= 1'b0;
      last_char <= 1'b0;
      pt_done   <= 1'b0;
      pos       <= '0;
    end else begin
      strobe    <= 1'b0;
      last_char <= 1'b0;
      if (active) begin
        strobe <= 1'b1;
        if (point_due) begin
          ascii_char <= bda_pkg::CHAR_POINT;
          pt_done    <= 1'b1;
        end else begin
          ascii_char <= bda_pkg::CHAR_ZERO + {3'b000, dig[idx]};
          last_char  <= last_digit;
          pos        <= pos + 1'b1;
          if (last_digit) begin
            active <= 1'b0;
          end
        end
      end
      if (load) begin
        active  <= 1'b1;
        pos     <= '0;
        pt_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= fmt;
      dig <= digits;
    end
  end

endmodule
`default_nettype wire

>>> design/binary_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to zero padded decimal ASCII
// Converts a value with a double dabble row of digit cells and streams the
// digits as characters, with an optional decimal point.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  input     start, busy, value                         start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//  result    strobe, ascii_char, last_char              strobe, one cycle each
//
//  The cell row takes 3 bits per cycle.
//  A string is digit_count characters, plus one for the point, one per cycle.
//  Conversion overlaps output: a new value converts while the last one streams.
//  Reset sets digit_count to 10 and frac_digits to 0 and drops work in flight.
//  The receiver cannot stall: each character is strobed for one cycle only.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  [bda_pkg::VALUE_BITS-1:0]     value,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [bda_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [bda_pkg::CFG_BITS-1:0]       cfg_data,
  output logic                               strobe,
  output logic [6:0]                         ascii_char,
  output logic                               last_char
);

  logic [bda_pkg::CFG_BITS-1:0]   digit_count;
  logic [bda_pkg::CFG_BITS-1:0]   frac_digits;
  bda_pkg::fmt_t                  fmt;
  logic                           conv_full;
  logic                           ser_free;
  logic                           take;
  bda_pkg::digit_t                digits [bda_pkg::MAX_DIGITS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= bda_pkg::DIGIT_COUNT_RESET;
      frac_digits <= bda_pkg::FRAC_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bda_pkg::REG_DIGIT_COUNT: digit_count <= cfg_data;
        bda_pkg::REG_FRAC_DIGITS: frac_digits <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero count means one digit, big counts saturate, fraction stays below count
  always_comb begin
    if (digit_count == '0) begin
      fmt.nd = bda_pkg::COUNT_BITS'(1);
    end else if (int'(digit_count) > bda_pkg::MAX_DIGITS) begin
      fmt.nd = bda_pkg::COUNT_BITS'(bda_pkg::MAX_DIGITS);
    end else begin
      fmt.nd = bda_pkg::COUNT_BITS'(digit_count);
    end
    if (int'(frac_digits) >= int'(fmt.nd)) begin
      fmt.nf = fmt.nd - 1'b1;
    end else begin
      fmt.nf = bda_pkg::COUNT_BITS'(frac_digits);
    end
  end

  assign take = conv_full && ser_free;

  bda_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (value),
    .take   (take),
    .busy   (busy),
    .full   (conv_full),
    .digits (digits)
  );

  bda_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .fmt        (fmt),
    .digits     (digits),
    .free       (ser_free),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  // the serializer goes active on the handover and strobes in the cycle after
  a_take_emits : assert property (@(posedge clk) disable iff (rst)
    take |-> ##2 strobe)
    else $error("digits handed over but no character followed");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not occupy the converter");

  a_take_needs_free : assert property (@(posedge clk) disable iff (rst)
    take |-> ser_free && conv_full)
    else $error("handover while serializer still streaming");

endmodule
`default_nettype wire
